FILE: rtl/seam_pkg.sv
// shared constants, register indexes and a helper function for the seam cost block
// no dependencies; imported by seam_cost_energy_dp
package seam_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// dimension arithmetic width, holds up to 8191
	localparam int DIM_W = 13;
	localparam int PIX_W = 25;
	localparam int TERM_W = 24;
	localparam int COST_W = 32;
	localparam int ACC_W = 26;
	localparam int SQ_W = 50;

	localparam logic [COST_W-1:0] BLOCKED_ENERGY = COST_W'(1) << 30;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// start bits of the root iteration, 25 and 13 result bits
	localparam logic [SQ_W-1:0] SQ_BIT_HI = SQ_W'(1) << 48;
	localparam logic [SQ_W-1:0] SQ_BIT_LO = SQ_W'(1) << 24;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ALPHA  = 2'd2;
	localparam logic [1:0] REG_MODE   = 2'd3;

	localparam logic [10:0] WIDTH_RST  = 11'd1024;
	localparam logic [10:0] HEIGHT_RST = 11'd1024;
	localparam logic [8:0]  ALPHA_RST  = 9'd128;

	// energy jobs of one item
	localparam logic [1:0] JOB_UPPER = 2'd0;
	localparam logic [1:0] JOB_LEFT  = 2'd1;
	localparam logic [1:0] JOB_LAST  = 2'd2;

	// per-channel absolute differences, packed as bytes
	function automatic logic [TERM_W-1:0] abs_terms(input logic [TERM_W-1:0] p,
		input logic [TERM_W-1:0] q);
		logic [TERM_W-1:0] t;
		logic [7:0] a;
		logic [7:0] b;
		t = '0;
		for (int k = 0; k < 3; k++) begin
			a = p[8*k +: 8];
			b = q[8*k +: 8];
			t[8*k +: 8] = (a > b) ? a - b : b - a;
		end
		return t;
	endfunction

endpackage

FILE: rtl/seam_cost_energy_dp.sv
// top level of the seam cost block: line memories, energy sequencer, root unit, apb registers
// depends on seam_pkg
//
// Computes the cumulative minimum vertical-seam cost of a raster pixel stream. Each input item
// is one rgb pixel with its blocked flag; results (cost in Q8, row, column, image_done on tlast)
// come one row late: a pixel in row r>0 yields the cost of the pixel above it, and in the last
// row also the cost of its left neighbor, plus its own cost at the last column. Costs saturate at
// 2^32-1, blocked pixels have energy 2^30. One item is handled at a time by a sequencer around two
// line memories (pixel row and cost row, one write and one registered read port each): an accept
// state and the line reads, then per result one energy job of a setup, a multiply-accumulate over
// the six channel terms, a bit-serial root (in gradient_mode 0 square root of 25 bits then of 13
// bits; in mode 1 of 13 bits) and a state to hand over the result, and a final writeback. A blocked
// job skips accumulate and root. Row 0 runs no job, inner rows one job per item and the last row up
// to three jobs per item, for the pixel above, the left neighbor and the last column. The output
// register lets the next item start while the last result waits on m_tready. Configure only
// while idle; sizes clamp to 2..MAX_WIDTH/HEIGHT.
module seam_cost_energy_dp #(
	parameter int MAX_WIDTH  = seam_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = seam_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic        s_tuser,   // blocked
	// cost items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // cost [31:0], pixel_row [41:32], pixel_column [51:42], zero pad
	output logic        m_tlast,   // image_done
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import seam_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_JOB  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_SQ   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_WB   = 3'd6;

	// per-item position flags
	typedef struct packed {
		logic r_pos;
		logic r_one;
		logic last_row;
		logic c_pos;
		logic c_ge2;
		logic c_right;
		logic c_last;
	} pos_t;

	// configuration registers
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [8:0]  alpha_q;
	logic        mode_q;

	logic [2:0]        state_q;
	logic [AW-1:0]     col_q;
	logic [HW-1:0]     row_q;
	logic [AW-1:0]     cur_c_q;
	logic [HW-1:0]     cur_r_q;
	pos_t              pos_q;
	logic [PIX_W-1:0]  pix_q;
	logic [2:0]        rd_cnt_q;
	logic [1:0]        job_q;

	// values read from the line memories
	logic [PIX_W-1:0]  old_q;
	logic [PIX_W-1:0]  right_q;
	logic [PIX_W-1:0]  prev_q;
	logic [COST_W-1:0] cl_c_q;
	logic [COST_W-1:0] cl_r_q;
	logic [COST_W-1:0] cl_l_q;
	logic [COST_W-1:0] cl_l2_q;

	// state carried between items
	logic [PIX_W-1:0]  held_pixel_q;
	logic [TERM_W-1:0] held_down_q;
	logic [COST_W-1:0] replaced_q;

	// energy job
	logic [TERM_W-1:0] tx_q;
	logic [TERM_W-1:0] ty_q;
	logic [COST_W-1:0] min_q;
	logic [COST_W-1:0] energy_q;
	logic [COST_W-1:0] cost0_q;
	logic [2:0]        acc_cnt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [15:0]       sq_s1;
	logic [8:0]        wgt_s1;
	logic [SQ_W-1:0]   sx_q;
	logic [SQ_W-1:0]   sr_q;
	logic [SQ_W-1:0]   sb_q;
	logic              pass_q;

	// output register
	logic              out_valid_q;
	logic [COST_W-1:0] out_cost_q;
	logic [9:0]        out_row_q;
	logic [9:0]        out_col_q;
	logic              out_done_q;

	// line memories
	logic [PIX_W-1:0]  pix_mem [MAX_WIDTH];
	logic [COST_W-1:0] cost_mem [MAX_WIDTH];
	logic [AW-1:0]     pix_ra;
	logic [AW-1:0]     cost_ra;
	logic [PIX_W-1:0]  pix_rd;
	logic [COST_W-1:0] cost_rd;
	logic              pix_we;
	logic              cost_we;
	logic [COST_W-1:0] cost_wd;

	// clamped configuration
	logic [DIM_W-1:0] w_dim;
	logic [DIM_W-1:0] h_dim;
	logic [8:0]       alpha_eff;
	logic [8:0]       alpha_inv;

	logic             in_acc;
	logic             slot_free;
	logic [AW-1:0]    c_in;
	logic [HW-1:0]    r_in;
	logic [DIM_W-1:0] c_dim;
	logic [DIM_W-1:0] r_dim;
	logic             wrap;

	logic [7:0]        term;
	logic [24:0]       prod;
	logic [ACC_W-1:0]  acc_sum;
	logic [SQ_W-1:0]   sq_try;
	logic              sq_take;
	logic [COST_W:0]   sum_wide;
	logic [COST_W-1:0] sum_sat;
	logic [COST_W-1:0] job_cost;
	logic [TERM_W-1:0] dnow;
	logic [TERM_W-1:0] dleft;
	logic [TERM_W-1:0] jx;
	logic [TERM_W-1:0] jy;
	logic              jblk;
	logic [COST_W-1:0] jmin;
	logic              more_left;
	logic              more_last;

	assign pready = 1'b1;

	always_comb begin
		w_dim = DIM_W'(width_q);
		if (w_dim < DIM_W'(2)) w_dim = DIM_W'(2);
		else if (w_dim > DIM_W'(MAX_WIDTH)) w_dim = DIM_W'(MAX_WIDTH);
		h_dim = DIM_W'(height_q);
		if (h_dim < DIM_W'(2)) h_dim = DIM_W'(2);
		else if (h_dim > DIM_W'(MAX_HEIGHT)) h_dim = DIM_W'(MAX_HEIGHT);
	end

	assign alpha_eff = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
	assign alpha_inv = 9'd256 - alpha_eff;

	// apb registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			alpha_q  <= ALPHA_RST;
			mode_q   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[10:0];
				REG_ALPHA:  alpha_q  <= pwdata[8:0];
				REG_MODE:   mode_q   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_ALPHA:  prdata = 32'(alpha_q);
			REG_MODE:   prdata = 32'(mode_q);
			default:    prdata = '0;
		endcase
	end

	// input position, counters restart if the size shrank under them
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign wrap     = (DIM_W'(row_q) >= h_dim) || (DIM_W'(col_q) >= w_dim);
	assign c_in     = wrap ? '0 : col_q;
	assign r_in     = wrap ? '0 : row_q;
	assign c_dim    = DIM_W'(c_in);
	assign r_dim    = DIM_W'(r_in);

	assign slot_free = !out_valid_q || m_tready;

	// read sequence: pixel c, c+1, c-1; cost c, c+1, c-1, c-2
	always_comb begin
		case (rd_cnt_q)
			3'd0: begin
				pix_ra  = cur_c_q;
				cost_ra = cur_c_q;
			end
			3'd1: begin
				pix_ra  = cur_c_q + AW'(1);
				cost_ra = cur_c_q + AW'(1);
			end
			3'd2: begin
				pix_ra  = cur_c_q - AW'(1);
				cost_ra = cur_c_q - AW'(1);
			end
			default: begin
				pix_ra  = cur_c_q - AW'(1);
				cost_ra = cur_c_q - AW'(2);
			end
		endcase
	end

	assign pix_we  = (state_q == ST_WB);
	assign cost_we = (state_q == ST_FIN) && slot_free && (job_q == JOB_UPPER);
	assign cost_wd = job_cost;

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[cur_c_q] <= pix_q;
		pix_rd <= pix_mem[pix_ra];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cur_c_q] <= cost_wd;
		cost_rd <= cost_mem[cost_ra];
	end

	// job operands
	assign dnow  = abs_terms(pix_q[TERM_W-1:0], old_q[TERM_W-1:0]);
	assign dleft = abs_terms(pix_q[TERM_W-1:0], prev_q[TERM_W-1:0]);

	always_comb begin
		jx   = dleft;
		jy   = dnow;
		jblk = pix_q[24];
		jmin = (cost0_q < cl_l_q) ? cost0_q : cl_l_q;
		case (job_q)
			JOB_UPPER: begin
				jx = pos_q.c_right ? abs_terms(right_q[TERM_W-1:0], old_q[TERM_W-1:0])
					: abs_terms(old_q[TERM_W-1:0], held_pixel_q[TERM_W-1:0]);
				jy   = dnow;
				jblk = old_q[24];
				jmin = cl_c_q;
				if (pos_q.c_pos && replaced_q < jmin) jmin = replaced_q;
				if (pos_q.c_right && cl_r_q < jmin) jmin = cl_r_q;
			end
			JOB_LEFT: begin
				jx   = dleft;
				jy   = held_down_q;
				jblk = prev_q[24];
				jmin = cl_l_q;
				if (pos_q.c_ge2 && cl_l2_q < jmin) jmin = cl_l2_q;
				if (cost0_q < jmin) jmin = cost0_q;
			end
			default: ;
		endcase
	end

	// weighted term sum, one channel term a cycle
	always_comb begin
		case (acc_cnt_q)
			3'd0:    term = tx_q[7:0];
			3'd1:    term = tx_q[15:8];
			3'd2:    term = tx_q[23:16];
			3'd3:    term = ty_q[7:0];
			3'd4:    term = ty_q[15:8];
			default: term = ty_q[23:16];
		endcase
	end

	assign prod    = wgt_s1 * sq_s1;
	assign acc_sum = acc_q + ACC_W'(prod);

	// bit-serial root step
	assign sq_try  = sr_q + sb_q;
	assign sq_take = (sx_q >= sq_try);

	// saturating cost
	assign sum_wide = {1'b0, energy_q} + {1'b0, min_q};
	assign sum_sat  = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
	assign job_cost = (job_q == JOB_UPPER && pos_q.r_one) ? energy_q : sum_sat;

	assign more_left = pos_q.last_row && pos_q.c_pos;
	assign more_last = pos_q.c_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			cur_c_q      <= '0;
			cur_r_q      <= '0;
			pos_q        <= '0;
			rd_cnt_q     <= '0;
			job_q        <= JOB_UPPER;
			acc_cnt_q    <= '0;
			pass_q       <= 1'b0;
			held_pixel_q <= '0;
			held_down_q  <= '0;
			replaced_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// a result loads the free slot, otherwise a taken result empties it
			if (state_q == ST_FIN && slot_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cur_c_q        <= c_in;
						cur_r_q        <= r_in;
						pos_q.r_pos    <= (r_dim != '0);
						pos_q.r_one    <= (r_dim == DIM_W'(1));
						pos_q.last_row <= (r_dim == h_dim - DIM_W'(1));
						pos_q.c_pos    <= (c_dim != '0);
						pos_q.c_ge2    <= (c_dim >= DIM_W'(2));
						pos_q.c_right  <= (c_dim + DIM_W'(1) < w_dim);
						pos_q.c_last   <= (c_dim == w_dim - DIM_W'(1));
						rd_cnt_q       <= '0;
						if (c_dim + DIM_W'(1) < w_dim) begin
							col_q <= c_in + AW'(1);
							row_q <= r_in;
						end else begin
							col_q <= '0;
							row_q <= (r_dim + DIM_W'(1) < h_dim) ? r_in + HW'(1) : '0;
						end
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						job_q   <= JOB_UPPER;
						state_q <= pos_q.r_pos ? ST_JOB : ST_WB;
					end
				end
				ST_JOB: begin
					acc_cnt_q <= '0;
					if (jblk) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					acc_cnt_q <= acc_cnt_q + 3'd1;
					if (acc_cnt_q == 3'd6) begin
						pass_q  <= 1'b0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (sb_q[0]) begin
						if (!mode_q && !pass_q) pass_q <= 1'b1;
						else state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						if (job_q == JOB_UPPER && more_left) begin
							job_q   <= JOB_LEFT;
							state_q <= ST_JOB;
						end else if (job_q == JOB_LEFT && more_last) begin
							job_q   <= JOB_LAST;
							state_q <= ST_JOB;
						end else begin
							state_q <= ST_WB;
						end
					end
				end
				ST_WB: begin
					held_pixel_q <= old_q;
					if (pos_q.last_row) held_down_q <= dnow;
					if (pos_q.r_pos) replaced_q <= cl_c_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) pix_q <= {s_tuser, s_tdata};
		if (state_q == ST_RD) begin
			case (rd_cnt_q)
				3'd1: begin
					old_q  <= pix_rd;
					cl_c_q <= cost_rd;
				end
				3'd2: begin
					right_q <= pix_rd;
					cl_r_q  <= cost_rd;
				end
				3'd3: begin
					prev_q <= pix_rd;
					cl_l_q <= cost_rd;
				end
				3'd4: cl_l2_q <= cost_rd;
				default: ;
			endcase
		end
		if (state_q == ST_JOB) begin
			tx_q  <= jx;
			ty_q  <= jy;
			min_q <= jmin;
			acc_q <= '0;
			if (jblk) energy_q <= BLOCKED_ENERGY;
		end
		if (state_q == ST_ACC) begin
			if (acc_cnt_q != 3'd6) begin
				sq_s1  <= mode_q ? 16'(term) : term * term;
				wgt_s1 <= (acc_cnt_q < 3'd3) ? alpha_eff : alpha_inv;
			end
			if (acc_cnt_q != 3'd0) acc_q <= acc_sum;
			if (acc_cnt_q == 3'd6) begin
				sr_q <= '0;
				if (mode_q) begin
					sx_q <= SQ_W'(acc_sum) << 8;
					sb_q <= SQ_BIT_LO;
				end else begin
					sx_q <= SQ_W'(acc_sum) << 24;
					sb_q <= SQ_BIT_HI;
				end
			end
		end
		if (state_q == ST_SQ) begin
			if (sb_q[0] && !mode_q && !pass_q) begin
				// second root of the first root gives the fourth root
				sx_q <= sq_take ? (sr_q >> 1) + sb_q : sr_q >> 1;
				sr_q <= '0;
				sb_q <= SQ_BIT_LO;
			end else begin
				if (sq_take) begin
					sx_q <= sx_q - sq_try;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
				if (sb_q[0]) energy_q <= COST_W'(sq_take ? (sr_q >> 1) + sb_q : sr_q >> 1);
			end
		end
		if (state_q == ST_FIN && slot_free) begin
			out_cost_q <= job_cost;
			out_done_q <= (job_q == JOB_LAST);
			out_row_q  <= (job_q == JOB_UPPER) ? 10'(DIM_W'(cur_r_q) - DIM_W'(1))
				: 10'(DIM_W'(cur_r_q));
			out_col_q  <= (job_q == JOB_LEFT) ? 10'(DIM_W'(cur_c_q) - DIM_W'(1))
				: 10'(DIM_W'(cur_c_q));
			if (job_q == JOB_UPPER) cost0_q <= job_cost;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_col_q, out_row_q, out_cost_q};
	assign m_tlast  = out_done_q;

`ifndef SYNTHESIS
	// an accepted item always starts the read sequence
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RD) && (rd_cnt_q == 3'd0))
		else $error("item accepted without starting the line reads");

	// the root iteration keeps a single weight bit
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> $onehot(sb_q))
		else $error("root weight bit lost");

	// a result is only loaded into a free output slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(out_cost_q) && $stable(out_done_q))
		else $error("pending cost item overwritten");

	// image end only comes from the last-column job
	a_done_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && slot_free && job_q == JOB_LAST) |-> pos_q.c_last && pos_q.last_row)
		else $error("image end outside the last pixel");
`endif

endmodule
